FILE: hw/rtl/lagdiff_pkg.sv
// ----------------------------------------------------------------------------
// lagdiff_pkg
// Shared types and constants for the lagged differentiator (DT1 element).
// ----------------------------------------------------------------------------
package lagdiff_pkg;

    // Input transaction: one sample and its enable bit
    typedef struct packed {
        logic signed [31:0] sample_in;
        logic               enable;
    } in_item_t;

    // Output transaction: one result per accepted sample
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               enable_out;
        logic [13:0]        cycle_count;
    } out_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_T1,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_PREP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIFF_GAIN    = 2'd0;
    localparam logic [1:0] CFG_LAG_RATIO    = 2'd1;
    localparam logic [1:0] CFG_CYCLE_PERIOD = 2'd2;

    // Register reset values, unsigned Q16.16
    localparam logic [31:0] DIFF_GAIN_RST    = 32'd65536;
    localparam logic [31:0] LAG_RATIO_RST    = 32'd6554;
    localparam logic [31:0] CYCLE_PERIOD_RST = 32'd65536;

    // Step counter wraps after this value
    localparam logic [13:0] COUNT_LAST = 14'd9999;

    // Serial divider: one quotient bit per cycle over a 65-bit dividend
    localparam int          DIV_CNT_W  = 7;
    localparam logic [6:0]  DIV_LAST   = 7'd64;

endpackage

FILE: hw/rtl/lagged_differentiator.sv
// ----------------------------------------------------------------------------
// lagged_differentiator
// Backward-Euler DT1 step (derivative with first-order lag) in Q16.16,
// built on one shared 32x32 multiplier and a restoring serial divider.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | direction | payload
//  --------+---------------------------------------+-----------+------------------
//  in      | in_valid, in_ready, in_data           | sink      | in_item_t
//  out     | out_valid, out_ready, out_data        | source    | out_item_t
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | sink      | 2-bit index, 32b
//
//  Sequence: an enabled transaction runs three multiplier passes, one
//  sum/denominator step, 65 divider steps and one finish step before the
//  next is accepted. A zero denominator skips the divider. A disabled
//  transaction goes from idle straight to the finish step.
//  in_ready is high only while the sequencer idles.
//  Reset: asynchronous, active low; restores register defaults and clears
//  the stored input, output and step counter.
//  Stalls: the result sits in an output register; the next transaction is
//  accepted while it waits, and only the finish step holds for a free slot.
//  cfg_ready is always high; a write to an unused index is dropped.
//
module lagged_differentiator #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lagdiff_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lagdiff_pkg::out_item_t out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    // Saturation width is capped at the 32-bit port width
    localparam int          SAT_W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic [62:0] POS_LIM = 63'((64'd1 << (SAT_W - 1)) - 64'd1);
    localparam logic [62:0] NEG_LIM = 63'(64'd1 << (SAT_W - 1));

    // ---------------- state ----------------
    lagdiff_pkg::state_t state_reg, state_next;

    logic [31:0]        diff_gain_reg, lag_ratio_reg, cycle_period_reg;
    logic signed [31:0] last_input_reg, last_output_reg;
    logic [13:0]        step_count_reg;

    logic               en_reg;
    logic               hold_reg;
    logic [31:0]        dmag_reg;
    logic               dneg_reg;
    logic [31:0]        t1_reg;
    logic [63:0]        p1_reg, p2_reg;
    logic [64:0]        dividend_reg;
    logic               neg_reg;
    logic [32:0]        den_reg;
    logic [32:0]        rem_reg;
    logic [64:0]        quot_reg;
    logic [lagdiff_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic                   out_valid_reg;
    lagdiff_pkg::out_item_t out_data_reg;

    // ---------------- control outputs ----------------
    logic        in_fire;
    logic        finish_fire;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;

    // ---------------- datapath helpers ----------------
    logic [32:0] in_diff;
    logic [31:0] last_out_mag;
    logic [64:0] mag_sum;
    logic [32:0] den_sum;
    logic [33:0] rem_shift;
    logic        rem_ge;
    logic        quot_ovf;
    logic [62:0] quot_mag;
    logic [62:0] sat_mag;
    logic signed [31:0] result_next;
    logic [13:0] step_count_next;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lagdiff_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_data.enable ? lagdiff_pkg::ST_MUL_T1
                                                : lagdiff_pkg::ST_FINISH;
                end
            end
            lagdiff_pkg::ST_MUL_T1: state_next = lagdiff_pkg::ST_MUL_P1;
            lagdiff_pkg::ST_MUL_P1: state_next = lagdiff_pkg::ST_MUL_P2;
            lagdiff_pkg::ST_MUL_P2: state_next = lagdiff_pkg::ST_PREP;
            lagdiff_pkg::ST_PREP:
            begin
                // zero denominator: skip the divider, output holds
                state_next = (den_sum == '0) ? lagdiff_pkg::ST_FINISH
                                             : lagdiff_pkg::ST_DIVIDE;
            end
            lagdiff_pkg::ST_DIVIDE:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = lagdiff_pkg::ST_FINISH;
                end
            end
            lagdiff_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = lagdiff_pkg::ST_IDLE;
                end
            end
            default: state_next = lagdiff_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        in_ready    = 1'b0;
        finish_fire = 1'b0;
        mul_a       = lag_ratio_reg;
        mul_b       = diff_gain_reg;
        case (state_reg)
            lagdiff_pkg::ST_IDLE:   in_ready = 1'b1;
            lagdiff_pkg::ST_MUL_T1:
            begin
                mul_a = lag_ratio_reg;
                mul_b = diff_gain_reg;
            end
            lagdiff_pkg::ST_MUL_P1:
            begin
                mul_a = t1_reg;
                mul_b = last_out_mag;
            end
            lagdiff_pkg::ST_MUL_P2:
            begin
                mul_a = diff_gain_reg;
                mul_b = dmag_reg;
            end
            lagdiff_pkg::ST_FINISH: finish_fire = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The one shared multiplier; its product is registered in the multiplier states
    assign mul_prod = 64'(mul_a) * 64'(mul_b);

    // u - u_prev, 33-bit signed
    assign in_diff = {in_data.sample_in[31], in_data.sample_in}
                   - {last_input_reg[31], last_input_reg};

    assign last_out_mag = last_output_reg[31] ? (32'd0 - last_output_reg)
                                              : last_output_reg;

    // Signed sum of the two products as sign plus 65-bit magnitude
    always_comb
    begin
        if (last_output_reg[31] == dneg_reg)
        begin
            mag_sum = {1'b0, p1_reg} + {1'b0, p2_reg};
        end
        else if (p1_reg >= p2_reg)
        begin
            mag_sum = {1'b0, p1_reg - p2_reg};
        end
        else
        begin
            mag_sum = {1'b0, p2_reg - p1_reg};
        end
    end

    assign den_sum = {1'b0, cycle_period_reg} + {1'b0, t1_reg};

    // Restoring division step
    assign rem_shift = {rem_reg, dividend_reg[64]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};

    // Quotient bits 64 and 63 mean overflow
    assign quot_ovf = quot_reg[64] | quot_reg[63];
    assign quot_mag = quot_reg[62:0];

    always_comb
    begin
        if (neg_reg)
        begin
            sat_mag     = (quot_ovf || quot_mag > NEG_LIM) ? NEG_LIM : quot_mag;
            result_next = 32'd0 - sat_mag[31:0];
        end
        else
        begin
            sat_mag     = (quot_ovf || quot_mag > POS_LIM) ? POS_LIM : quot_mag;
            result_next = sat_mag[31:0];
        end
        if (hold_reg)
        begin
            result_next = last_output_reg;
        end
    end

    assign step_count_next = (step_count_reg == lagdiff_pkg::COUNT_LAST) ? 14'd0
                                                                         : step_count_reg + 14'd1;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lagdiff_pkg::ST_IDLE;
            diff_gain_reg    <= lagdiff_pkg::DIFF_GAIN_RST;
            lag_ratio_reg    <= lagdiff_pkg::LAG_RATIO_RST;
            cycle_period_reg <= lagdiff_pkg::CYCLE_PERIOD_RST;
            last_input_reg   <= '0;
            last_output_reg  <= '0;
            step_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lagdiff_pkg::CFG_DIFF_GAIN:    diff_gain_reg    <= cfg_data;
                    lagdiff_pkg::CFG_LAG_RATIO:    lag_ratio_reg    <= cfg_data;
                    lagdiff_pkg::CFG_CYCLE_PERIOD: cycle_period_reg <= cfg_data;
                    default:                       diff_gain_reg    <= diff_gain_reg;
                endcase
            end

            if (in_fire)
            begin
                last_input_reg <= in_data.sample_in;
                step_count_reg <= step_count_next;
            end

            if (finish_fire)
            begin
                last_output_reg <= result_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lagdiff_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    en_reg   <= in_data.enable;
                    hold_reg <= !in_data.enable;
                    dneg_reg <= in_diff[32];
                    dmag_reg <= in_diff[32] ? 32'(33'd0 - in_diff) : in_diff[31:0];
                end
            end
            lagdiff_pkg::ST_MUL_T1:
            begin
                // t1 = (ratio * td) >> 16, saturated to 32 bits
                t1_reg <= (mul_prod[63:48] != '0) ? '1 : mul_prod[47:16];
            end
            lagdiff_pkg::ST_MUL_P1: p1_reg <= mul_prod;
            lagdiff_pkg::ST_MUL_P2: p2_reg <= mul_prod;
            lagdiff_pkg::ST_PREP:
            begin
                dividend_reg <= mag_sum;
                neg_reg      <= (last_output_reg[31] == dneg_reg) ? dneg_reg
                              : ((p1_reg >= p2_reg) ? last_output_reg[31] : dneg_reg);
                den_reg      <= den_sum;
                hold_reg     <= (den_sum == '0);
                rem_reg      <= '0;
                quot_reg     <= '0;
                div_cnt_reg  <= lagdiff_pkg::DIV_LAST;
            end
            lagdiff_pkg::ST_DIVIDE:
            begin
                dividend_reg <= {dividend_reg[63:0], 1'b0};
                rem_reg      <= rem_ge ? 33'(rem_shift - {1'b0, den_reg}) : rem_shift[32:0];
                quot_reg     <= {quot_reg[63:0], rem_ge};
                div_cnt_reg  <= div_cnt_reg - 7'd1;
            end
            lagdiff_pkg::ST_FINISH:
            begin
                if (finish_fire)
                begin
                    out_data_reg.result_value <= result_next;
                    out_data_reg.enable_out   <= en_reg;
                    out_data_reg.cycle_count  <= step_count_reg;
                end
            end
            default:
            begin
                en_reg <= en_reg;
            end
        endcase
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lagged_differentiator. A local DT1 predictor tracks
// the stored input, output and step counter, and each result is compared
// field by field. Directed extremes come first, then random register settings
// with random sample streams, then a burst of back-to-back held steps.
// ----------------------------------------------------------------------------
module testbench;

    // Stall limits and drain times in clock cycles, then print and test sizes
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 80;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 210;
    localparam int HELD_BURST     = 24;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    lagdiff_pkg::in_item_t in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lagdiff_pkg::out_item_t out_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [1:0]  cfg_index = lagdiff_pkg::CFG_DIFF_GAIN;
    logic [31:0] cfg_data  = '0;

    lagged_differentiator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow copy of the registers and of the element's
    // memory. Registers must only change while the block is idle (the block does
    // not enforce it), so the shadow registers are updated when the write is accepted.
    // ------------------------------------------------------------------------
    logic [31:0]        gain_q;
    logic [31:0]        ratio_q;
    logic [31:0]        period_q;
    logic signed [31:0] prev_sample;
    logic signed [31:0] prev_result;
    logic [13:0]        step_cnt;

    lagdiff_pkg::out_item_t predicted_outputs[$];

    int  error_count     = 0;
    int  results_checked = 0;
    int  samples_sent    = 0;
    int  enabled_sent    = 0;
    int  settings_used   = 0;
    int  wraps_seen      = 0;
    int  idle_cycles     = 0;
    int  ready_hold      = 0;
    // Random idling on both channels; switched off for some phases
    bit  idling          = 1'b1;

    // One backward-Euler DT1 step. The numerator is built as sign plus a
    // 65-bit magnitude, divided by the 33-bit denominator with truncation
    // toward zero, then clamped to the signed 32-bit range.
    function automatic logic signed [31:0] dt1_response(input logic signed [31:0] u);
        logic [63:0]        lag_prod;
        logic [31:0]        t1;
        logic [32:0]        den;
        logic               out_neg;
        logic [31:0]        out_mag;
        logic signed [32:0] delta;
        logic               delta_neg;
        logic [32:0]        delta_mag;
        logic [63:0]        p1;
        logic [63:0]        p2;
        logic [64:0]        num;
        logic               num_neg;
        logic [64:0]        quo;
        logic [31:0]        mag;
        lag_prod = {32'b0, ratio_q} * {32'b0, gain_q};
        // t1 saturates to the unsigned Q16.16 range
        t1  = (lag_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : lag_prod[47:16];
        den = {1'b0, period_q} + {1'b0, t1};
        // Zero denominator: output holds
        if (den == 33'd0)
            return prev_result;
        out_neg   = prev_result[31];
        out_mag   = out_neg ? (~prev_result + 32'd1) : prev_result;
        delta     = {u[31], u} - {prev_sample[31], prev_sample};
        delta_neg = delta[32];
        delta_mag = delta_neg ? (~delta + 33'd1) : delta;
        p1 = {32'b0, t1} * {32'b0, out_mag};
        p2 = {32'b0, gain_q} * {31'b0, delta_mag};
        if (out_neg == delta_neg)
        begin
            num     = {1'b0, p1} + {1'b0, p2};
            num_neg = out_neg;
        end
        else if (p1 >= p2)
        begin
            num     = {1'b0, p1 - p2};
            num_neg = out_neg;
        end
        else
        begin
            num     = {1'b0, p2 - p1};
            num_neg = delta_neg;
        end
        quo = num / {32'b0, den};
        if (num_neg)
        begin
            mag = (quo > 65'h0_8000_0000) ? 32'h8000_0000 : quo[31:0];
            return ~mag + 32'd1;
        end
        return (quo > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    endfunction

    // Advances the shadow element by one accepted sample, returns its result
    function automatic lagdiff_pkg::out_item_t advance_element(
        input lagdiff_pkg::in_item_t item);
        lagdiff_pkg::out_item_t r;
        logic signed [31:0]     v;
        v = prev_result;
        if (item.enable)
            v = dt1_response(item.sample_in);
        prev_sample = item.sample_in;
        prev_result = v;
        step_cnt    = (step_cnt == lagdiff_pkg::COUNT_LAST) ? 14'd0 : step_cnt + 14'd1;
        r.result_value = v;
        r.enable_out   = item.enable;
        r.cycle_count  = step_cnt;
        return r;
    endfunction

    task automatic reset_model();
        gain_q      = lagdiff_pkg::DIFF_GAIN_RST;
        ratio_q     = lagdiff_pkg::LAG_RATIO_RST;
        period_q    = lagdiff_pkg::CYCLE_PERIOD_RST;
        prev_sample = '0;
        prev_result = '0;
        step_cnt    = '0;
    endtask

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure and the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if (idling && $urandom_range(0, 3) == 0)
        begin
            ready_hold <= pick_gap();
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        lagdiff_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: %h", out_data));
            end
            else
            begin
                want = predicted_outputs.pop_front();
                results_checked++;
                if (out_data.result_value !== want.result_value)
                    report_mismatch($sformatf("result_value %h, predicted %h (step %0d)",
                        out_data.result_value, want.result_value, want.cycle_count));
                if (out_data.enable_out !== want.enable_out)
                    report_mismatch($sformatf("enable_out %b, predicted %b (step %0d)",
                        out_data.enable_out, want.enable_out, want.cycle_count));
                if (out_data.cycle_count !== want.cycle_count)
                    report_mismatch($sformatf("cycle_count %0d, predicted %0d",
                        out_data.cycle_count, want.cycle_count));
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results pending",
                idle_cycles, predicted_outputs.size());
            $display("lagged_differentiator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers. All run just after a rising edge. The sample driver
    // leaves in_valid high after acceptance so a back-to-back transaction
    // needs only one assignment in that step; pauses lower it explicitly.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [31:0] value, input logic en);
        lagdiff_pkg::in_item_t item;
        int                    gap;
        item.sample_in = value;
        item.enable    = en;
        if (idling && $urandom_range(0, 2) == 0)
        begin
            gap = pick_gap() + 1;
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_outputs.push_back(advance_element(item));
        samples_sent++;
        if (en)
            enabled_sent++;
        if (step_cnt == 14'd0)
            wraps_seen++;
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            lagdiff_pkg::CFG_DIFF_GAIN:    gain_q   = value;
            lagdiff_pkg::CFG_LAG_RATIO:    ratio_q  = value;
            lagdiff_pkg::CFG_CYCLE_PERIOD: period_q = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] gain, input logic [31:0] ratio,
                              input logic [31:0] period);
        wait_idle();
        write_reg(lagdiff_pkg::CFG_DIFF_GAIN, gain);
        write_reg(lagdiff_pkg::CFG_LAG_RATIO, ratio);
        write_reg(lagdiff_pkg::CFG_CYCLE_PERIOD, period);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: held step, two enabled samples at the same level, a step down, held step
    task automatic test_reset_defaults();
        send_sample(32'sh0001_0000, 1'b0);
        send_sample(32'sh0001_0000, 1'b1);
        send_sample(32'sh0001_0000, 1'b1);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'sh0000_3039, 1'b0);
    endtask

    // Full-scale swings drive the quotient into both clamps
    task automatic test_input_extremes();
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh0000_0000, 1'b1);
        send_sample(32'shFFFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
    endtask

    // No cycle time and no lag: output holds while enable_out still follows
    task automatic test_zero_denominator();
        set_config(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'sh0004_0000, 1'b1);
        send_sample(32'shFFF0_0000, 1'b1);
    endtask

    // Register corners: saturated t1, pure derivative, no gain, tiny values
    task automatic test_register_extremes();
        logic [31:0] corners [4][3];
        corners = '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001},
                    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001}};
        foreach (corners[k])
        begin
            set_config(corners[k][0], corners[k][1], corners[k][2]);
            send_sample(32'sh7FFF_FFFF, 1'b1);
            send_sample(32'sh8000_0000, 1'b1);
            send_sample($urandom, 1'b1);
        end
    endtask

    // Mostly moderate register values so outputs stay in range,
    // a quarter of them anywhere in the 32-bit space
    function automatic logic [31:0] pick_register(input logic [1:0] idx);
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0)
            v = $urandom;
        else if (idx == lagdiff_pkg::CFG_DIFF_GAIN)
            v = $urandom_range(32'h0000_1000, 32'h0004_0000);
        else if (idx == lagdiff_pkg::CFG_LAG_RATIO)
            v = $urandom_range(32'h0000_0000, 32'h0003_0000);
        else
            v = $urandom_range(32'h0000_0400, 32'h0004_0000);
        if (idx == lagdiff_pkg::CFG_CYCLE_PERIOD && v == 32'd0)
            v = 32'd1;
        return v;
    endfunction

    // Random settings, each with a stream of samples: part full range, part a
    // small random walk around the last sample, most of them enabled
    task automatic test_random_phases();
        logic signed [31:0] value;
        int                 nudge;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idling = (ph != 2);
            set_config(pick_register(lagdiff_pkg::CFG_DIFF_GAIN),
                       pick_register(lagdiff_pkg::CFG_LAG_RATIO),
                       pick_register(lagdiff_pkg::CFG_CYCLE_PERIOD));
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    value = $urandom;
                end
                else
                begin
                    nudge = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                    value = prev_sample + nudge;
                end
                send_sample(value, $urandom_range(0, 4) != 0);
                // Occasional full drain mid-stream
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
        end
        idling = 1'b1;
    endtask

    // Held steps are quick, so run a burst of them back to back, then check
    // that enabled steps pick up from the held output
    task automatic test_held_burst();
        set_config(lagdiff_pkg::DIFF_GAIN_RST, lagdiff_pkg::LAG_RATIO_RST,
                   lagdiff_pkg::CYCLE_PERIOD_RST);
        idling = 1'b0;
        repeat (HELD_BURST) send_sample($urandom, 1'b0);
        idling = 1'b1;
        repeat (6) send_sample($urandom, 1'b1);
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (predicted_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_outputs.size()));
        $display("Covered %0d samples (%0d enabled) over %0d register settings;",
            samples_sent, enabled_sent, settings_used);
        $display("%0d results checked, step counter wrapped %0d time(s), %0d mismatches.",
            results_checked, wraps_seen, error_count);
        if (error_count == 0)
            $display("lagged_differentiator verification clean");
        else
            $display("lagged_differentiator verification failed");
        $finish;
    endtask

    initial
    begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_input_extremes();
        test_zero_denominator();
        test_register_extremes();
        test_random_phases();
        test_held_burst();
        finish_run();
    end

endmodule
